[rtl/min_of_set_not_in_other_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the set-difference minimum core
// ---------------------------------------------------------------------------
`ifndef MIN_OF_SET_NOT_IN_OTHER_CORE_DEFINES_SVH
`define MIN_OF_SET_NOT_IN_OTHER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, quiet in reset
`define MSNIO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSNIO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/msnio_pkg.sv]
// ---------------------------------------------------------------------------
// msnio_pkg
// Shared types and constants of the set-difference minimum core.
// ---------------------------------------------------------------------------
package msnio_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_W       = 32;
  localparam int CFG_W        = 5;

  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(10);
  localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_ELEMENTS);
  localparam logic [IDX_W-1:0] LAST_SLOT   = IDX_W'(MAX_ELEMENTS - 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] value;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_a_addr;
    logic [IDX_W-1:0] rd_b_addr;
    logic             scan_valid;
    logic             scan_first;
    logic             scan_last;
    logic             clear;
    logic             load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/msnio_ram.sv]
// ---------------------------------------------------------------------------
// msnio_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module msnio_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/msnio_dp.sv]
// ---------------------------------------------------------------------------
// msnio_dp
// Set stores, compare stage, running minimum and output register.
// ---------------------------------------------------------------------------
module msnio_dp (
  input  logic                clk,
  input  logic                rst,
  input  msnio_pkg::in_item_t in_data,
  input  msnio_pkg::dp_cmd_t  cmd,
  output msnio_pkg::dp_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output msnio_pkg::out_item_t out_data
);

  import msnio_pkg::*;

  logic [DATA_W-1:0] a_rd;
  logic [DATA_W-1:0] b_rd;
  logic              stg_valid;
  logic              stg_first;
  logic              stg_last;
  logic              absent;
  logic              absent_next;
  logic              found;
  logic signed [DATA_W-1:0] best;
  logic              take;

  msnio_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_first_set (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (in_data.a_value),
    .rd_en   (cmd.scan_valid),
    .rd_addr (cmd.rd_a_addr),
    .rd_data (a_rd)
  );

  msnio_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_second_set (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (in_data.b_value),
    .rd_en   (cmd.scan_valid),
    .rd_addr (cmd.rd_b_addr),
    .rd_data (b_rd)
  );

  // a_rd stays absent while no second-set entry matches it
  always_comb begin
    absent_next = (stg_first | absent) & (a_rd != b_rd);
    take        = stg_valid & stg_last & absent_next &
                  (!found | ($signed(a_rd) < best));
  end

  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      stg_valid <= cmd.scan_valid;
      if (cmd.clear) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_first <= cmd.scan_first;
    stg_last  <= cmd.scan_last;
    if (stg_valid) begin
      absent <= absent_next;
    end
    if (take) begin
      best <= $signed(a_rd);
    end
    if (cmd.load_out) begin
      out_data.found <= found;
      out_data.value <= found ? best : '0;
    end
  end

endmodule

[rtl/msnio_ctrl.sv]
// ---------------------------------------------------------------------------
// msnio_ctrl
// Batch loading, pairwise scan sequencing and result hand-off.
// ---------------------------------------------------------------------------
module msnio_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [msnio_pkg::CFG_W-1:0] cfg_data,
  output msnio_pkg::dp_cmd_t          cmd,
  input  msnio_pkg::dp_stat_t         stat
);

  import msnio_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] element_count;
  logic [CNT_W-1:0] loaded_count;
  logic [CNT_W-1:0] total;
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;

  logic [CNT_W-1:0] eff_count;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] total_next;
  logic [CNT_W-1:0] total_m1;
  logic [IDX_W-1:0] last_idx;
  logic             last_item;
  logic             accept;

  always_comb begin
    if (element_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(element_count) > 32'(MAX_ELEMENTS)) begin
      eff_count = MAX_CNT;
    end else begin
      eff_count = CNT_W'(element_count);
    end
    slot       = (loaded_count >= MAX_CNT) ? LAST_SLOT : loaded_count[IDX_W-1:0];
    total_next = CNT_W'(slot) + CNT_W'(1);
    last_item  = total_next >= eff_count;
    total_m1   = total - CNT_W'(1);
    last_idx   = total_m1[IDX_W-1:0];
    accept     = in_valid && !in_stall;
  end

  assign in_stall  = (state != S_LOAD);
  assign cfg_ready = 1'b1;

  always_comb begin
    cmd.wr_en      = accept;
    cmd.wr_addr    = slot;
    cmd.rd_a_addr  = i_idx;
    cmd.rd_b_addr  = j_idx;
    cmd.scan_valid = (state == S_SCAN);
    cmd.scan_first = (j_idx == '0);
    cmd.scan_last  = (j_idx == last_idx);
    cmd.clear      = accept && last_item;
    cmd.load_out   = (state == S_FINISH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      element_count <= COUNT_RESET;
      loaded_count  <= '0;
      total         <= CNT_W'(1);
      i_idx         <= '0;
      j_idx         <= '0;
    end else begin
      if (cfg_valid) begin
        element_count <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (last_item) begin
              total        <= total_next;
              loaded_count <= '0;
              i_idx        <= '0;
              j_idx        <= '0;
              state        <= S_SCAN;
            end else begin
              loaded_count <= total_next;
            end
          end
        end
        S_SCAN: begin
          if (j_idx == last_idx) begin
            j_idx <= '0;
            if (i_idx == last_idx) begin
              state <= S_DRAIN;
            end else begin
              i_idx <= i_idx + IDX_W'(1);
            end
          end else begin
            j_idx <= j_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // last compare is still in the datapath stage
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (stat.out_free) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

[rtl/min_of_set_not_in_other_core.sv]
// ---------------------------------------------------------------------------
// min_of_set_not_in_other_core
// Smallest first-set value that is absent from the second set.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------
//  in      | in_valid/in_stall  | in_data  (a_value, b_value)
//  out     | out_valid/out_stall| out_data (found, value)
//  cfg     | cfg_valid/cfg_ready| cfg_data (element_count)
//
//  Pairs load one per cycle while in_stall is low (it is high outside the
//  load state). After the last pair of a batch the compare scan reads one
//  first/second-set pair per cycle, over all pairs, through the two set RAM
//  read ports; the compare stage and a drain state precede the out register.
//  Synchronous reset clears control state; element_count returns to 10.
//  A stalled result holds; the next batch loads and scans meanwhile, and its
//  result waits in the finish state until the previous result is taken.
// ---------------------------------------------------------------------------
module min_of_set_not_in_other_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  msnio_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output msnio_pkg::out_item_t        out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [msnio_pkg::CFG_W-1:0] cfg_data
);

  import msnio_pkg::*;

  `include "min_of_set_not_in_other_core_defines.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  msnio_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  msnio_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `MSNIO_ASSERT_NOW(a_no_load_in_scan, cmd.scan_valid, in_stall, "request taken during scan")
  `MSNIO_ASSERT_NOW(a_wr_on_accept, cmd.wr_en, in_valid && !in_stall, "store write without request")
  `MSNIO_ASSERT_NOW(a_load_out_free, cmd.load_out, stat.out_free, "result overwritten")
  `MSNIO_ASSERT_NEXT(a_out_after_load, cmd.load_out, out_valid, "result not presented")

endmodule

[bench/min_of_set_not_in_other_core_test.sv]
// ---------------------------------------------------------------------------
// min_of_set_not_in_other_core_test
// Self-checking bench for the set-difference minimum core. Pairs are loaded
// in batches under a range of element counts, including zero, the largest
// sizes and a count lowered part-way through a batch. A scoreboard predicts
// each batch result and checks results in order. Both sides idle at random,
// and one long output hold lets the core fill up and stall its input.
// ---------------------------------------------------------------------------
module min_of_set_not_in_other_core_test;
  import msnio_pkg::*;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] ALT_LO  = 32'sh5555_5555;
  localparam logic signed [DATA_W-1:0] ALT_HI  = 32'shAAAA_AAAA;
  // one full batch at the largest size, plus margin
  localparam int SCAN_SETTLE    = MAX_ELEMENTS + MAX_ELEMENTS * MAX_ELEMENTS + 2 + 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TOTAL_PAIRS    = 620;

  typedef enum int {WIDE, NARROW, MIRRORED, EDGES} value_mix_t;

  class set_diff_scoreboard;
    logic [CFG_W-1:0]         count_reg;
    int                       loaded;
    logic signed [DATA_W-1:0] first_set  [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] second_set [MAX_ELEMENTS];
    out_item_t                expected_q [$];
    int                       errors;

    function new();
      count_reg = COUNT_RESET;
      loaded    = 0;
      errors    = 0;
    endfunction

    static function int batch_size(logic [CFG_W-1:0] c);
      if (c == 0) return 1;
      if (int'(c) > MAX_ELEMENTS) return MAX_ELEMENTS;
      return int'(c);
    endfunction

    function void write_count(logic [CFG_W-1:0] v);
      count_reg = v;
    endfunction

    // store the pair; at the end of a batch work out the smallest absent value
    function void note_request(in_item_t item);
      int                       slot;
      int                       total;
      bit                       hit;
      bit                       absent;
      logic signed [DATA_W-1:0] best;
      out_item_t                res;
      slot = (loaded >= MAX_ELEMENTS) ? MAX_ELEMENTS - 1 : loaded;
      first_set[slot]  = item.a_value;
      second_set[slot] = item.b_value;
      total = slot + 1;
      if (total < batch_size(count_reg)) begin
        loaded = total;
        return;
      end
      hit  = 1'b0;
      best = '0;
      for (int i = 0; i < total; i++) begin
        absent = 1'b1;
        for (int j = 0; j < total; j++)
          if (first_set[i] == second_set[j]) absent = 1'b0;
        if (absent && (!hit || first_set[i] < best)) begin
          best = first_set[i];
          hit  = 1'b1;
        end
      end
      loaded    = 0;
      res.found = hit;
      res.value = hit ? best : '0;
      expected_q.push_back(res);
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with none pending: found=%0b value=%0d",
                         got.found, got.value));
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found: got %0b, want %0b", got.found, want.found));
      if (got.value !== want.value)
        report($sformatf("value: got %0d, want %0d", got.value, want.value));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  set_diff_scoreboard sb = new();
  int items_sent   = 0;
  int quiet_cycles = 0;
  bit stall_free   = 1'b0;
  bit hold_pending = 1'b0;

  min_of_set_not_in_other_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // values seen here are those before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (cfg_valid && cfg_ready) sb.write_count(cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall per result, one long hold when asked
  initial begin : receiver
    int pause;
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pause = stall_free ? 0 : $urandom_range(0, 5);
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pair(input logic signed [DATA_W-1:0] a,
                           input logic signed [DATA_W-1:0] b);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{a_value: a, b_value: b};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic program_count(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // a partial batch gives no result, so the core may still be busy: settle too
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(value_mix_t mix);
    case (mix)
      WIDE:    return $urandom;
      NARROW:  return $urandom_range(0, 8) - 4;
      EDGES: begin
        case ($urandom_range(0, 4))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return '0;
          3:       return '1;
          default: return $urandom;
        endcase
      end
      default: return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20) - 10;
    endcase
  endfunction

  // batches of random content; the budget need not be a whole number of batches
  task automatic run_phase(input logic [CFG_W-1:0] count, input int budget);
    int                       size;
    int                       sent;
    int                       rot;
    value_mix_t               mix;
    logic signed [DATA_W-1:0] a_set [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] b_set [MAX_ELEMENTS];
    wait_drained();
    program_count(count);
    size = set_diff_scoreboard::batch_size(count);
    sent = 0;
    while (sent < budget) begin
      mix = value_mix_t'($urandom_range(0, 3));
      rot = $urandom_range(0, size - 1);
      for (int i = 0; i < size; i++) a_set[i] = pick_value(mix);
      for (int i = 0; i < size; i++)
        b_set[i] = (mix == MIRRORED) ? a_set[(i + rot) % size] : pick_value(mix);
      // mirrored sets mostly give no result flag; now and then break one entry
      if (mix == MIRRORED && $urandom_range(0, 1))
        b_set[$urandom_range(0, size - 1)] = pick_value(NARROW);
      for (int i = 0; i < size && sent < budget; i++) begin
        send_pair(a_set[i], b_set[i]);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] count;
    int               budget;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of ten: extremes and duplicates, every first-set value present
    send_pair(INT_MAX, INT_MIN);
    send_pair(INT_MIN, '0);
    send_pair('0, 3);
    send_pair('1, 5);
    send_pair(1, ALT_LO);
    send_pair(5, INT_MAX);
    send_pair(5, '1);
    send_pair(ALT_LO, ALT_HI);
    send_pair(ALT_HI, 1);
    send_pair(-7, -7);
    wait_drained();

    // count of zero behaves as one
    program_count('0);
    send_pair(INT_MIN, INT_MAX);
    send_pair(INT_MAX, INT_MIN);
    send_pair('0, '0);
    wait_drained();

    // lowering the count part-way through closes the batch on the next request
    program_count(CFG_W'(4));
    send_pair(INT_MAX, 1);
    send_pair(2, 2);
    send_pair(-5, 3);
    wait_drained();
    program_count(CFG_W'(2));
    send_pair(7, INT_MAX);

    stall_free = 1'b1;
    run_phase('1, 34);
    stall_free = 1'b0;
    run_phase(CFG_W'(16), 33);
    run_phase(CFG_W'(1), 20);

    // long output hold while requests keep coming
    hold_pending = 1'b1;
    stall_free   = 1'b1;
    run_phase(CFG_W'(4), 60);
    stall_free   = 1'b0;

    while (items_sent < TOTAL_PAIRS) begin
      case ($urandom_range(0, 9))
        0: begin
          count  = CFG_W'($urandom_range(0, 1));
          budget = $urandom_range(10, 30);
        end
        1: begin
          count  = CFG_W'($urandom_range(16, 31));
          budget = 2 * MAX_ELEMENTS + $urandom_range(0, 5);
        end
        default: begin
          count  = CFG_W'($urandom_range(2, 9));
          budget = $urandom_range(20, 60);
        end
      endcase
      stall_free = ($urandom_range(0, 3) == 0);
      run_phase(count, budget);
    end

    wait_drained();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
